[sv/hts_pkg.sv]
// Shared constants, types and the sine table builder for the harmonic tone generator.
// Used by hts_tone, hts_gain and the top level; depends on nothing else.
package hts_pkg;

    // Field and register widths.
    localparam int IDX_W      = 16;
    localparam int PHASE_W    = 32;
    localparam int NOTE_LEN_W = 17;
    localparam int CFG_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = 1;

    // Design constants.
    localparam int MAX_SAMPLES      = 65536;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int HARMONICS        = 4;

    localparam int MAX_LEN_W = $clog2(MAX_SAMPLES + 1);
    localparam int LEN_W     = (MAX_LEN_W > NOTE_LEN_W) ? MAX_LEN_W : NOTE_LEN_W;

    // Fade length is the note length over twenty, by a reciprocal multiply.
    localparam int FADE_DIV   = 20;
    localparam int FADE_W     = $clog2(MAX_SAMPLES / FADE_DIV + 2);
    localparam int FADE_SHIFT = LEN_W + 5;
    localparam int FMULT_W    = LEN_W + 1;
    localparam int FPROD_W    = LEN_W + FMULT_W;
    localparam logic [FMULT_W-1:0] FADE_MULT = FMULT_W'((2 ** FADE_SHIFT) / FADE_DIV + 1);

    // Sine table: only the first quarter wave plus its end point is stored.
    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR    = SINE_TABLE_DEPTH / 4;
    localparam int QIDX_W = ADDR_W - 1;
    localparam int SINE_W = 15;

    // Harmonic weights in Q0.15.
    localparam int WEIGHT_W = 13;
    localparam logic [WEIGHT_W-1:0] HARM_WEIGHT [4] = '{13'd5041, 13'd2521, 13'd1512, 13'd756};

    localparam int SVAL_W    = SINE_W + 1;
    localparam int PROD_W    = SVAL_W + WEIGHT_W + 1;
    localparam int ACC_W     = PROD_W + 2;
    localparam int MIX_W     = 16;
    localparam int MIX_SHIFT = 15;

    // Gain is a Q0.15 quotient; full gain travels as a flag.
    localparam int GAIN_FRAC = 15;
    localparam int GPROD_W   = MIX_W + GAIN_FRAC + 1;

    // Depths in register stages after the input register; OUT_LAT also counts it and the result register.
    localparam int TONE_LAT = 4;
    localparam int GAIN_LAT = GAIN_FRAC + 2;
    localparam int MIX_DLY  = GAIN_LAT - TONE_LAT;
    localparam int OUT_LAT  = GAIN_LAT + 2;

    // Register reset values.
    localparam logic [PHASE_W-1:0]    PHASE_STEP_RST  = 32'd39370534;
    localparam logic [NOTE_LEN_W-1:0] NOTE_LENGTH_RST = 17'd48000;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PHASE_STEP  = 1'b0,
        REG_NOTE_LENGTH = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic valid;
        logic in_note;
        logic full;
    } t_gain_ctl;

    localparam longint unsigned HALF_PI_Q62 = 64'd7244019458077122842;
    localparam longint unsigned X_STEP      = HALF_PI_Q62 / SINE_TABLE_DEPTH;

    // (a*b) >> 62 on 64-bit unsigned operands, truncated to 64 bits.
    function automatic longint unsigned mul_q62(longint unsigned a, longint unsigned b);
        longint unsigned al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
        al  = a & 64'hFFFF_FFFF;
        ah  = a >> 32;
        bl  = b & 64'hFFFF_FFFF;
        bh  = b >> 32;
        ll  = al * bl;
        lh  = al * bh;
        hl  = ah * bl;
        hh  = ah * bh;
        mid = (ll >> 32) + (lh & 64'hFFFF_FFFF) + (hl & 64'hFFFF_FFFF);
        lo  = (mid << 32) | (ll & 64'hFFFF_FFFF);
        hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
        return (hi << 2) | (lo >> 62);
    endfunction

    // Unsigned 64-bit quotient by restoring long division, one bit per step.
    // The divisor stays small, so the partial remainder never overflows.
    function automatic longint unsigned udiv_u64(longint unsigned num, longint unsigned den);
        longint unsigned quo, rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Rounded 32767*sin of quarter-wave point q, by a fixed-point Taylor series.
    // Evaluated only while the design elaborates.
    function automatic logic [SINE_W-1:0] quarter_sine(int unsigned q);
        longint unsigned x, x2, term, sum, sh, sl, hiw, low, v;
        x    = X_STEP * 64'(4 * q);
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n < 40; n++) begin
            if (term != 64'd0) begin
                term = udiv_u64(mul_q62(term, x2), 64'(2 * n) * 64'(2 * n + 1));
                if ((n & 1) != 0) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        sh  = sum >> 31;
        sl  = sum & 64'h7FFF_FFFF;
        hiw = 64'd32767 * sh;
        low = 64'd32767 * sl + (64'd1 << 61);
        v   = (hiw + (low >> 31)) >> 31;
        return SINE_W'(v);
    endfunction

endpackage

[sv/hts_tone.sv]
// Tone datapath: phase multiply, harmonic table lookup, weighting and sum.
// Four register stages from index to mixed sample; depends on hts_pkg.
module hts_tone (
    input  logic                             i_clk,
    input  logic [hts_pkg::IDX_W-1:0]        i_idx,
    input  logic [hts_pkg::PHASE_W-1:0]      i_phase_step,
    output logic signed [hts_pkg::MIX_W-1:0] o_mix
);
    import hts_pkg::*;

    logic [SINE_W-1:0] w_rom [QTR+1];

    logic [PHASE_W-1:0]       r_phase;
    logic [SINE_W-1:0]        r_mag  [HARMONICS];
    logic                     r_neg  [HARMONICS];
    logic signed [PROD_W-1:0] r_prod [HARMONICS];
    logic signed [ACC_W-1:0]  w_sum;
    logic signed [MIX_W-1:0]  r_mix;

    for (genvar g = 0; g <= QTR; g++) begin : g_rom
        localparam logic [SINE_W-1:0] C_VAL = quarter_sine(g);
        assign w_rom[g] = C_VAL;
    end

    // Stage 1: fundamental phase, modulo one cycle.
    always_ff @(posedge i_clk) begin
        r_phase <= PHASE_W'(PHASE_W'(i_idx) * i_phase_step);
    end

    for (genvar h = 0; h < HARMONICS; h++) begin : g_harm
        logic [PHASE_W-1:0]      w_hph;
        logic [ADDR_W-1:0]       w_addr;
        logic [QIDX_W-1:0]       w_qidx;
        logic signed [SVAL_W-1:0] w_sval;

        // The second address bit selects a falling quarter, the top bit the sign.
        always_comb begin
            w_hph  = PHASE_W'(r_phase * PHASE_W'(h + 1));
            w_addr = w_hph[PHASE_W-1 -: ADDR_W];
            if (w_addr[ADDR_W-2]) begin
                w_qidx = QIDX_W'(QTR) - QIDX_W'(w_addr[ADDR_W-3:0]);
            end else begin
                w_qidx = QIDX_W'(w_addr[ADDR_W-3:0]);
            end
            w_sval = r_neg[h] ? -$signed(SVAL_W'(r_mag[h])) : $signed(SVAL_W'(r_mag[h]));
        end

        // Stage 2: table lookup; stage 3: weighting.
        always_ff @(posedge i_clk) begin
            r_mag[h]  <= w_rom[w_qidx];
            r_neg[h]  <= w_addr[ADDR_W-1];
            r_prod[h] <= w_sval * $signed({1'b0, HARM_WEIGHT[h]});
        end
    end

    always_comb begin
        w_sum = '0;
        for (int h = 0; h < HARMONICS; h++) begin
            w_sum = w_sum + ACC_W'(r_prod[h]);
        end
    end

    // Stage 4: sum, floored back to Q1.15.
    always_ff @(posedge i_clk) begin
        r_mix <= MIX_W'(w_sum >>> MIX_SHIFT);
    end

    assign o_mix = r_mix;

endmodule

[sv/hts_gain.sv]
// Fade gain: range checks, then a pipelined restoring divider, one quotient bit a stage.
// Gives floor(r*2^15/fade) or a full-gain flag; depends on hts_pkg.
module hts_gain (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [hts_pkg::IDX_W-1:0]        i_idx,
    input  logic [hts_pkg::LEN_W-1:0]        i_len,
    input  logic [hts_pkg::FADE_W-1:0]       i_fade,
    output hts_pkg::t_gain_ctl               o_ctl,
    output logic [hts_pkg::GAIN_FRAC-1:0]    o_quot
);
    import hts_pkg::*;

    logic [LEN_W-1:0] w_idx;
    logic [LEN_W-1:0] w_fade;
    logic [LEN_W-1:0] w_r;

    t_gain_ctl        r_g1_ctl;
    logic             r_g1_lt;
    logic [LEN_W-1:0] r_g1_idx;
    logic [LEN_W-1:0] r_g1_dist;

    t_gain_ctl           r_ctl  [GAIN_FRAC+1];
    logic [FADE_W-1:0]   r_rem  [GAIN_FRAC+1];
    logic [GAIN_FRAC-1:0] r_quot [GAIN_FRAC+1];

    assign w_idx  = LEN_W'(i_idx);
    assign w_fade = LEN_W'(i_fade);
    assign w_r    = r_g1_lt ? r_g1_idx : r_g1_dist;

    // Stage 1: position against the note and the fades.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1_ctl <= '0;
        end else begin
            r_g1_ctl.valid   <= i_valid;
            r_g1_ctl.in_note <= w_idx < i_len;
            r_g1_ctl.full    <= 1'b0;
        end
        r_g1_lt   <= w_idx < w_fade;
        r_g1_idx  <= w_idx;
        r_g1_dist <= LEN_W'(i_len - w_idx);
    end

    // Stage 2: a distance of a whole fade or more means full gain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else begin
            r_ctl[0].valid   <= r_g1_ctl.valid;
            r_ctl[0].in_note <= r_g1_ctl.in_note;
            r_ctl[0].full    <= w_r >= w_fade;
        end
        r_rem[0]  <= FADE_W'(w_r);
        r_quot[0] <= '0;
    end

    for (genvar k = 1; k <= GAIN_FRAC; k++) begin : g_div
        logic [FADE_W:0] w_rem2;
        logic            w_ge;

        assign w_rem2 = {r_rem[k-1], 1'b0};
        assign w_ge   = w_rem2 >= {1'b0, i_fade};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else begin
                r_ctl[k] <= r_ctl[k-1];
            end
            r_rem[k]  <= w_ge ? FADE_W'(w_rem2 - {1'b0, i_fade}) : FADE_W'(w_rem2);
            r_quot[k] <= {r_quot[k-1][GAIN_FRAC-2:0], w_ge};
        end
    end

    assign o_ctl  = r_ctl[GAIN_FRAC];
    assign o_quot = r_quot[GAIN_FRAC];

endmodule

[sv/harmonic_tone_sample_generator.sv]
// Top level of the harmonic tone sample generator: register port, input stage,
// tone and gain pipelines, fade multiply and result register. Depends on hts_pkg,
// hts_tone and hts_gain.
//
//   Channel   | Ports                                          | Handshake
//   ----------+------------------------------------------------+------------------------
//   request   | start, busy, i_sample_index                    | taken on start && !busy
//   result    | o_strobe, o_sample_value, o_in_note            | one cycle, no back-pressure
//   registers | psel, penable, pwrite, paddr, pwdata, prdata   | APB-style, pready tied high
//
// A request may enter in every clock cycle. Its result reaches the result ports through
// the input register, the gain pipeline and the result register; the depth is set
// by the gain divider, which produces one quotient bit per stage, and the tone path
// waits for it in a delay line.
// Reset is synchronous and active low; it empties the pipeline and holds busy high.
// Nothing stalls: busy falls at the first edge after reset is released and stays low,
// and results flow out in request order, one per accepted request.
module harmonic_tone_sample_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [hts_pkg::IDX_W-1:0]         i_sample_index,
    output logic                              o_strobe,
    output logic signed [hts_pkg::MIX_W-1:0]  o_sample_value,
    output logic                              o_in_note,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hts_pkg::PADDR_W-1:0]       paddr,
    input  logic [hts_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [hts_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import hts_pkg::*;

    // Register port.
    logic                  w_wr;
    t_reg_idx              w_reg_idx;
    logic [PHASE_W-1:0]    r_phase_step;
    logic [NOTE_LEN_W-1:0] r_note_length;

    // Values derived from the note length, refreshed every cycle.
    logic [LEN_W-1:0]   w_len_ext;
    logic [LEN_W-1:0]   w_len_c;
    logic [LEN_W-1:0]   r_len_c;
    logic [FPROD_W-1:0] r_fade_prod;
    logic [FADE_W-1:0]  w_fade_q;
    logic [FADE_W-1:0]  w_fade;

    // Input stage.
    logic             r_busy;
    logic             w_accept;
    logic             r_p0_valid;
    logic [IDX_W-1:0] r_p0_idx;

    // Pipelines and output.
    logic signed [MIX_W-1:0]   w_mix;
    logic signed [MIX_W-1:0]   r_mix_dly [MIX_DLY];
    t_gain_ctl                 w_gctl;
    logic [GAIN_FRAC-1:0]      w_quot;
    logic signed [GPROD_W-1:0] w_gain_prod;
    logic signed [MIX_W-1:0]   n_sample;
    logic                      r_strobe;
    logic                      r_in_note;
    logic signed [MIX_W-1:0]   r_sample;

    // The register index is the word address; every address maps to a register.
    assign w_wr      = psel && penable && pwrite;
    assign w_reg_idx = t_reg_idx'(paddr[PADDR_W-1 -: REG_IDX_W]);
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step  <= PHASE_STEP_RST;
            r_note_length <= NOTE_LENGTH_RST;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                REG_PHASE_STEP:  r_phase_step  <= pwdata;
                REG_NOTE_LENGTH: r_note_length <= pwdata[NOTE_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_PHASE_STEP:  prdata = r_phase_step;
            REG_NOTE_LENGTH: prdata = CFG_DATA_W'(r_note_length);
            default:         prdata = '0;
        endcase
    end

    // Lengths above the maximum saturate. The fade length is floor(len/20) by a
    // reciprocal multiply that is exact over the whole length range, and it is
    // never less than one sample. Both registers settle in the cycle after a write,
    // which is before the first request after it reaches the gain pipeline.
    assign w_len_ext = LEN_W'(r_note_length);
    assign w_len_c   = (w_len_ext > LEN_W'(MAX_SAMPLES)) ? LEN_W'(MAX_SAMPLES) : w_len_ext;

    always_ff @(posedge i_clk) begin
        r_len_c     <= w_len_c;
        r_fade_prod <= FPROD_W'(w_len_c) * FPROD_W'(FADE_MULT);
    end

    assign w_fade_q = r_fade_prod[FADE_SHIFT +: FADE_W];
    assign w_fade   = (w_fade_q == '0) ? FADE_W'(1) : w_fade_q;

    // Busy only covers reset; afterwards a request can be taken every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid <= 1'b0;
        end else begin
            r_p0_valid <= w_accept;
        end
        r_p0_idx <= i_sample_index;
    end

    // The tone path needs no valid bit: its stages only carry data, and the
    // gain pipeline, which is the deeper one, carries the valid bit.
    hts_tone u_tone (
        .i_clk        (i_clk),
        .i_idx        (r_p0_idx),
        .i_phase_step (r_phase_step),
        .o_mix        (w_mix)
    );

    hts_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p0_valid),
        .i_idx   (r_p0_idx),
        .i_len   (r_len_c),
        .i_fade  (w_fade),
        .o_ctl   (w_gctl),
        .o_quot  (w_quot)
    );

    // Delay line that lines the mixed sample up with its gain.
    always_ff @(posedge i_clk) begin
        r_mix_dly[0] <= w_mix;
        for (int i = 1; i < MIX_DLY; i++) begin
            r_mix_dly[i] <= r_mix_dly[i-1];
        end
    end

    // Fade multiply with a floor shift; full gain passes the sample unchanged, and
    // an index past the note gives silence.
    assign w_gain_prod = GPROD_W'(r_mix_dly[MIX_DLY-1]) * $signed(GPROD_W'({1'b0, w_quot}));

    always_comb begin
        if (!w_gctl.in_note) begin
            n_sample = '0;
        end else if (w_gctl.full) begin
            n_sample = r_mix_dly[MIX_DLY-1];
        end else begin
            n_sample = MIX_W'(w_gain_prod >>> GAIN_FRAC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_gctl.valid;
        end
        r_in_note <= w_gctl.in_note;
        r_sample  <= n_sample;
    end

    assign o_strobe       = r_strobe;
    assign o_in_note      = r_in_note;
    assign o_sample_value = r_sample;

`ifndef SYNTHESIS
    // Every accepted request produces its result strobe.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##OUT_LAT o_strobe)
        else $error("accepted request produced no result");

    // No result appears without a request accepted at the matching edge.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, OUT_LAT))
        else $error("result without a matching request");

    // A result outside the note is silent.
    a_silent_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_in_note) |-> (o_sample_value == '0))
        else $error("nonzero sample outside the note");

    // The in-note flag matches the index of the request it belongs to.
    a_in_note_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_in_note == $past(LEN_W'(i_sample_index) < w_len_c, OUT_LAT)))
        else $error("in-note flag does not match the request");
`endif

endmodule

[test/tone_sample_checker.sv]
`timescale 1ns / 100ps
// Result checker for the harmonic tone sample generator: follows the register
// port and the request channel, predicts each sample and compares it on the strobe.
// Depends on hts_pkg for widths, reset values and register indexes.
module tone_sample_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic [hts_pkg::IDX_W-1:0]           i_sample_index,
    input  logic                                i_strobe,
    input  logic [hts_pkg::MIX_W-1:0]           i_sample_value,
    input  logic                                i_in_note,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic                                i_pready,
    input  logic [hts_pkg::PADDR_W-1:0]         i_paddr,
    input  logic [hts_pkg::CFG_DATA_W-1:0]      i_pwdata,
    output int                                  o_pending,
    output int                                  o_mismatches
);

    localparam int LUT_DEPTH    = hts_pkg::SINE_TABLE_DEPTH;
    localparam int LUT_BITS     = $clog2(LUT_DEPTH);
    localparam int FADE_DIVISOR = 20;
    localparam int REPORT_LIMIT = 10;
    localparam longint unsigned QUARTER_TURN_Q62 = 64'd7244019458077122842;

    localparam logic [hts_pkg::PADDR_W-1:0] PHASE_STEP_ADDR =
        hts_pkg::PADDR_W'({hts_pkg::REG_PHASE_STEP, 2'b00});
    localparam logic [hts_pkg::PADDR_W-1:0] NOTE_LENGTH_ADDR =
        hts_pkg::PADDR_W'({hts_pkg::REG_NOTE_LENGTH, 2'b00});

    typedef struct packed {
        logic [hts_pkg::IDX_W-1:0] index;
        logic [hts_pkg::MIX_W-1:0] value;
        logic                      in_note;
    } tone_sample_t;

    int                                sine_lut [LUT_DEPTH];
    int                                harmonic_weight [4] = '{5041, 2521, 1512, 756};
    logic [hts_pkg::PHASE_W-1:0]       phase_step_reg;
    logic [hts_pkg::NOTE_LEN_W-1:0]    note_len_reg;
    tone_sample_t                      awaited_samples [$];
    int                                mismatch_count = 0;

    // Unsigned 64x64 product, scaled down by 2^62 and kept to 64 bits.
    function automatic longint unsigned q62_product(longint unsigned a, longint unsigned b);
        logic [127:0] full;
        full = 128'(a) * 128'(b);
        return full[125:62];
    endfunction

    // The table holds round(32767*sin) of each point, from a Taylor series in Q62.
    initial begin : build_sine_lut
        longint unsigned quad, x, x2, term, series;
        logic [127:0]    scaled;
        int              mag;
        bit              neg;
        for (int k = 0; k < LUT_DEPTH; k++) begin
            quad = 64'(4 * k);
            neg  = 1'b0;
            if (quad >= 64'(2 * LUT_DEPTH)) begin
                neg  = 1'b1;
                quad = quad - 64'(2 * LUT_DEPTH);
            end
            if (quad > 64'(LUT_DEPTH)) begin
                quad = 64'(2 * LUT_DEPTH) - quad;
            end
            x      = (QUARTER_TURN_Q62 / 64'(LUT_DEPTH)) * quad;
            x2     = q62_product(x, x);
            term   = x;
            series = x;
            for (int n = 1; n < 40 && term != 64'd0; n++) begin
                term = q62_product(term, x2) / (64'(2 * n) * 64'(2 * n + 1));
                if (n % 2 == 1) begin
                    series = series - term;
                end else begin
                    series = series + term;
                end
            end
            scaled      = 128'(series) * 128'd32767 + (128'd1 << 61);
            mag         = int'(scaled >> 62);
            sine_lut[k] = neg ? -mag : mag;
        end
    end

    // Expected sample for one index under the current register settings.
    function automatic tone_sample_t synth_sample(logic [hts_pkg::IDX_W-1:0] idx);
        tone_sample_t                res;
        int unsigned                 span, fade;
        logic [hts_pkg::PHASE_W-1:0] phase, harm_phase;
        longint                      mix, gain;
        res.index   = idx;
        res.value   = '0;
        res.in_note = 1'b0;
        span = (note_len_reg > hts_pkg::MAX_SAMPLES) ? hts_pkg::MAX_SAMPLES : note_len_reg;
        if (idx >= span) begin
            return res;
        end
        fade = span / FADE_DIVISOR;
        if (fade == 0) begin
            fade = 1;
        end
        phase = idx * phase_step_reg;
        mix   = 0;
        for (int h = 0; h < hts_pkg::HARMONICS; h++) begin
            harm_phase = phase * 32'(h + 1);
            mix = mix + longint'(harmonic_weight[h])
                      * longint'(sine_lut[harm_phase >> (hts_pkg::PHASE_W - LUT_BITS)]);
        end
        mix = mix >>> 15;
        if (idx < fade) begin
            gain = longint'(idx) * 32768 / longint'(fade);
        end else if (idx >= span - fade) begin
            gain = longint'(span - idx) * 32768 / longint'(fade);
        end else begin
            gain = 32768;
        end
        mix         = (mix * gain) >>> 15;
        res.value   = mix[hts_pkg::MIX_W-1:0];
        res.in_note = 1'b1;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        tone_sample_t want;
        if (!i_rst_n) begin
            awaited_samples.delete();
            phase_step_reg = hts_pkg::PHASE_STEP_RST;
            note_len_reg   = hts_pkg::NOTE_LENGTH_RST;
        end else begin
            // Results leave before new requests are booked at the same edge.
            if (i_strobe) begin
                if (awaited_samples.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected sample: value %0d in_note %0b", $realtime,
                                 $signed(i_sample_value), i_in_note);
                    end
                end else begin
                    want = awaited_samples.pop_front();
                    if (i_sample_value !== want.value || i_in_note !== want.in_note) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("%0t: index %0d: expected value %0d in_note %0b, got %0d %0b",
                                     $realtime, want.index, $signed(want.value), want.in_note,
                                     $signed(i_sample_value), i_in_note);
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                awaited_samples.push_back(synth_sample(i_sample_index));
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr)
                    PHASE_STEP_ADDR:  phase_step_reg = i_pwdata;
                    NOTE_LENGTH_ADDR: note_len_reg   = i_pwdata[hts_pkg::NOTE_LEN_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= awaited_samples.size();
        o_mismatches <= mismatch_count;
    end

endmodule

[test/tb_harmonic_tone_sample_generator.sv]
`timescale 1ns / 100ps
// Top of the harmonic tone sample generator testbench: clock, reset, register
// writes and sample requests. Depends on hts_pkg, the block and tone_sample_checker.
module tb_harmonic_tone_sample_generator;

    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int MAX_INDEX       = (1 << hts_pkg::IDX_W) - 1;

    localparam logic [hts_pkg::PADDR_W-1:0] PHASE_STEP_ADDR =
        hts_pkg::PADDR_W'({hts_pkg::REG_PHASE_STEP, 2'b00});
    localparam logic [hts_pkg::PADDR_W-1:0] NOTE_LENGTH_ADDR =
        hts_pkg::PADDR_W'({hts_pkg::REG_NOTE_LENGTH, 2'b00});

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic [hts_pkg::IDX_W-1:0]         i_sample_index;
    logic                              o_strobe;
    logic [hts_pkg::MIX_W-1:0]         o_sample_value;
    logic                              o_in_note;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [hts_pkg::PADDR_W-1:0]       paddr;
    logic [hts_pkg::CFG_DATA_W-1:0]    pwdata;
    logic [hts_pkg::CFG_DATA_W-1:0]    prdata;
    logic                              pready;

    int samples_outstanding;
    int mismatch_total;

    always #6 i_clk = ~i_clk;

    harmonic_tone_sample_generator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sample_index (i_sample_index),
        .o_strobe       (o_strobe),
        .o_sample_value (o_sample_value),
        .o_in_note      (o_in_note),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // The checker sits beside the block, sees the same pins and reports back
    // how many samples are still awaited and how many comparisons failed.
    tone_sample_checker sample_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_sample_index (i_sample_index),
        .i_strobe       (o_strobe),
        .i_sample_value (o_sample_value),
        .i_in_note      (o_in_note),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_pending      (samples_outstanding),
        .o_mismatches   (mismatch_total)
    );

    // One register write: a setup phase, then the access phase held until pready.
    // Afterwards the bus is left idle before the task returns, so back-to-back writes never
    // drive psel twice within the same time step.
    task automatic apb_write_reg(logic [hts_pkg::PADDR_W-1:0] addr,
                                 logic [hts_pkg::CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Issues one request. Before it, the sender may sit idle for a random
    // number of cycles, with junk on the index so that only start qualifies it.
    // The task returns right after the edge that accepted the request, with
    // start still high, so consecutive requests flow without a bubble.
    task automatic request_sample(logic [hts_pkg::IDX_W-1:0] idx, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start          <= 1'b0;
            i_sample_index <= hts_pkg::IDX_W'($urandom);
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_sample_index <= idx;
        do @(posedge i_clk); while (busy);
    endtask

    // Drops start and waits until every requested sample has come back. The
    // extra pipeline depth afterwards lets any stray strobe show up before
    // the registers are touched again.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (samples_outstanding != 0) begin
            @(posedge i_clk);
        end
        repeat (hts_pkg::OUT_LAT) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int                             directed_idx [10] =
            '{0, 1, 2399, 2400, 24000, 45599, 45600, 47999, 48000, MAX_INDEX};
        int                             idle_mix [3] = '{0, 68, 15};
        logic [hts_pkg::CFG_DATA_W-1:0] step_word, len_word;
        int                             span, fade, pick, idle_pct;

        start          <= 1'b0;
        i_sample_index <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        i_rst_n        <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n        <= 1'b1;
        @(posedge i_clk);

        // Reset settings: a 48000-sample note fades over 2400 samples, so the
        // list walks both fade edges, the middle, the last sample and past it.
        foreach (directed_idx[i]) begin
            request_sample(hts_pkg::IDX_W'(directed_idx[i]), 0);
        end
        drain_results();

        // Each phase writes both registers, then sends a batch of requests.
        // The early phases take the corner settings: a still phase, the fastest
        // step with a one-sample note, a zero-length note, a length that
        // saturates at the maximum, and short notes whose fade is one or two
        // samples. Later phases pick the settings at random.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    step_word = '0;
                    len_word  = hts_pkg::MAX_SAMPLES;
                end
                1: begin
                    step_word = '1;
                    len_word  = 1;
                end
                2: begin
                    step_word = $urandom;
                    len_word  = 0;
                end
                3: begin
                    step_word = $urandom;
                    len_word  = '1;
                end
                4: begin
                    step_word = $urandom;
                    len_word  = 19;
                end
                5: begin
                    step_word = $urandom;
                    len_word  = 40;
                end
                6: begin
                    step_word = $urandom_range(1, 1 << 20);
                    len_word  = hts_pkg::MAX_SAMPLES - 1;
                end
                default: begin
                    step_word = $urandom;
                    if ($urandom_range(3) == 0) begin
                        len_word = $urandom;
                    end else begin
                        len_word = $urandom_range(1, hts_pkg::MAX_SAMPLES);
                    end
                end
            endcase
            apb_write_reg(PHASE_STEP_ADDR, step_word);
            apb_write_reg(NOTE_LENGTH_ADDR, len_word);

            // Only the low register bits count, and the length saturates.
            span = int'(len_word[hts_pkg::NOTE_LEN_W-1:0]);
            if (span > hts_pkg::MAX_SAMPLES) begin
                span = hts_pkg::MAX_SAMPLES;
            end
            fade = (span / 20 > 0) ? span / 20 : 1;
            idle_pct = idle_mix[p % 3];

            // Indices lean toward the interesting spots: the fade-in, the start
            // of the fade-out, the end of the note, and the index extremes.
            repeat (ITEMS_PER_PHASE) begin
                case ($urandom_range(9))
                    0, 1:       pick = $urandom_range(MAX_INDEX);
                    2, 3, 4, 5: pick = (span > 0) ? $urandom_range(span - 1)
                                                  : $urandom_range(MAX_INDEX);
                    6:          pick = $urandom_range(fade + 2);
                    7:          pick = span - fade + $urandom_range(6) - 3;
                    8:          pick = span + $urandom_range(6) - 3;
                    default:    pick = $urandom_range(1) ? MAX_INDEX : 0;
                endcase
                if (pick < 0) begin
                    pick = 0;
                end
                if (pick > MAX_INDEX) begin
                    pick = MAX_INDEX;
                end
                request_sample(hts_pkg::IDX_W'(pick), idle_pct);
            end
            drain_results();
        end

        repeat (2 * hts_pkg::OUT_LAT) @(posedge i_clk);
        if (mismatch_total == 0 && samples_outstanding == 0) begin
            $display("** harmonic_tone_sample_generator: PASSED **");
        end else begin
            $display("** harmonic_tone_sample_generator: FAILED **");
        end
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this time.
    initial begin
        #2_000_000;
        $display("** harmonic_tone_sample_generator: FAILED **");
        $finish;
    end

endmodule
